@@ hw/rtl/stsub_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere triangle subdivider package
// Slot map of the vertex store, the midpoint schedule and the emission order.
// ----------------------------------------------------------------------------
package stsub_pkg;

    localparam int NUM_SLOTS = 18;
    localparam int SLOT_W    = 5;
    localparam int MAX_LEVEL = 2;
    localparam int NUM_MIDS  = 15;
    localparam int NUM_EMIT  = 63;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [1:0]        t_level;
    typedef logic [3:0]        t_mid_idx;
    typedef logic [5:0]        t_emit_idx;

    // Midpoint schedule: slot dst = normalize(slot src0 + slot src1).
    // The first three serve one split, all fifteen serve two splits.
    localparam t_slot MID_SRC0 [NUM_MIDS] = '{
        5'd0, 5'd1, 5'd2,  5'd0, 5'd3, 5'd5,  5'd3, 5'd1, 5'd4,
        5'd5, 5'd4, 5'd2,  5'd3, 5'd4, 5'd5};
    localparam t_slot MID_SRC1 [NUM_MIDS] = '{
        5'd1, 5'd2, 5'd0,  5'd3, 5'd5, 5'd0,  5'd1, 5'd4, 5'd3,
        5'd4, 5'd2, 5'd5,  5'd4, 5'd5, 5'd3};
    localparam t_slot MID_DST [NUM_MIDS] = '{
        5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11,
        5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17};

    // Emission order of the leaf vertices for each level, one list after another.
    localparam t_slot EMIT_TBL [NUM_EMIT] = '{
        5'd0, 5'd1, 5'd2,
        5'd0, 5'd3, 5'd5,   5'd3, 5'd1, 5'd4,   5'd5, 5'd4, 5'd2,   5'd3, 5'd4, 5'd5,
        5'd0, 5'd6, 5'd8,   5'd6, 5'd3, 5'd7,   5'd8, 5'd7, 5'd5,   5'd6, 5'd7, 5'd8,
        5'd3, 5'd9, 5'd11,  5'd9, 5'd1, 5'd10,  5'd11, 5'd10, 5'd4, 5'd9, 5'd10, 5'd11,
        5'd5, 5'd12, 5'd14, 5'd12, 5'd4, 5'd13, 5'd14, 5'd13, 5'd2, 5'd12, 5'd13, 5'd14,
        5'd3, 5'd15, 5'd17, 5'd15, 5'd4, 5'd16, 5'd17, 5'd16, 5'd5, 5'd15, 5'd16, 5'd17};

    function automatic t_mid_idx mid_count(input t_level lvl);
        case (lvl)
            2'd1:    mid_count = 4'd3;
            2'd2:    mid_count = 4'd15;
            default: mid_count = 4'd0;
        endcase
    endfunction

    function automatic t_emit_idx emit_base(input t_level lvl);
        case (lvl)
            2'd1:    emit_base = 6'd3;
            2'd2:    emit_base = 6'd15;
            default: emit_base = 6'd0;
        endcase
    endfunction

    function automatic t_emit_idx emit_len(input t_level lvl);
        case (lvl)
            2'd1:    emit_len = 6'd12;
            2'd2:    emit_len = 6'd48;
            default: emit_len = 6'd3;
        endcase
    endfunction

endpackage

@@ hw/rtl/stsub_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales a 3-vector to unit length, correctly rounded, with one shared
// multiplier and a bit-by-bit search of each component.
// ----------------------------------------------------------------------------
module stsub_norm #(
    parameter int FRAC_BITS = 14,
    parameter int CW        = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [3*CW-1:0]     i_vec,
    output logic                o_done,
    output logic [3*CW-1:0]     o_vec
);

    localparam int QW  = FRAC_BITS + 1;
    // Trial values reach about 2^(FRAC_BITS+2), so their square needs two
    // bits beyond twice the quotient width.
    localparam int TW  = 2 * QW + 2;
    localparam int SQW = 2 * CW;
    localparam int NW  = 2 * CW + 2;
    localparam int MA  = (CW > TW) ? CW : TW;
    localparam int MB  = NW;
    localparam int PW  = MA + MB;
    localparam int BW  = $clog2(QW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SQ   = 2'd1;
    localparam logic [1:0] S_TSQ  = 2'd2;
    localparam logic [1:0] S_TMUL = 2'd3;

    logic [1:0]            r_state;
    logic [CW-1:0]         r_mag [3];
    logic                  r_neg [3];
    logic [SQW-1:0]        r_sq  [3];
    logic [NW-1:0]         r_n;
    logic [TW-1:0]         r_t2;
    logic [QW-1:0]         r_q;
    logic [BW-1:0]         r_bit;
    logic [1:0]            r_comp;
    logic [CW-1:0]         r_res [3];
    logic                  r_done;

    logic [QW-1:0]         trial_q;
    logic [QW:0]           trial_t;
    logic [MA-1:0]         mul_a;
    logic [MB-1:0]         mul_b;
    logic [PW-1:0]         mul_p;
    logic [PW-1:0]         rhs;
    logic [QW-1:0]         q_next;
    logic signed [CW-1:0]  q_signed;

    always_comb begin
        trial_q = r_q | (QW'(1) << r_bit);
        trial_t = {trial_q, 1'b0} - (QW+1)'(1);
        case (r_state)
            S_SQ: begin
                mul_a = MA'(r_mag[r_comp]);
                mul_b = MB'(r_mag[r_comp]);
            end
            S_TSQ: begin
                mul_a = MA'(trial_t);
                mul_b = MB'(trial_t);
            end
            S_TMUL: begin
                mul_a = MA'(r_t2);
                mul_b = r_n;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p    = PW'(mul_a) * PW'(mul_b);
        rhs      = PW'({r_sq[r_comp], (2*QW)'(0)});
        q_next   = (mul_p <= rhs) ? trial_q : r_q;
        q_signed = CW'(q_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_comp  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SQ;
                        r_comp  <= '0;
                    end
                end
                S_SQ: begin
                    if (r_comp == 2'd2) begin
                        r_comp  <= '0;
                        r_state <= S_TSQ;
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                S_TSQ: begin
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_state <= S_TSQ;
                    if (r_bit == '0) begin
                        if (r_comp == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_comp <= r_comp + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    for (int c = 0; c < 3; c++) begin
                        r_neg[c] <= i_vec[c*CW + CW - 1];
                        r_mag[c] <= i_vec[c*CW + CW - 1] ? (CW'(0) - i_vec[c*CW +: CW])
                                                         : i_vec[c*CW +: CW];
                    end
                    r_n <= '0;
                end
            end
            S_SQ: begin
                r_sq[r_comp] <= SQW'(mul_p);
                r_n          <= r_n + NW'(mul_p);
                r_q          <= '0;
                r_bit        <= BW'(FRAC_BITS);
            end
            S_TSQ: begin
                r_t2 <= TW'(mul_p);
            end
            S_TMUL: begin
                if (r_bit == '0) begin
                    // A zero-length vector normalizes to zero.
                    if (r_n == '0) begin
                        r_res[r_comp] <= '0;
                    end else begin
                        r_res[r_comp] <= r_neg[r_comp] ? (-q_signed) : q_signed;
                    end
                    r_q   <= '0;
                    r_bit <= BW'(FRAC_BITS);
                end else begin
                    r_q   <= q_next;
                    r_bit <= r_bit - BW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_vec  = {r_res[2], r_res[1], r_res[0]};

endmodule

@@ hw/rtl/sphere_triangle_subdivider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere triangle subdivider
// Normalizes a fan triangle onto the unit sphere, splits it recursively and
// streams out the vertices of the leaf triangles with a running index.
// ----------------------------------------------------------------------------
// Usage: one word on the slave stream carries the cell center and two corner
// directions. The block then takes no word until the last vertex of that
// triangle has been taken on the master stream, which marks it with tlast.
// Every vertex is one output word: position and running index.
// Subdivision depth (0 to 2, the value 3 acts as 2) is to be written through
// the configuration port while the block is idle; the user is bound, the block
// itself does not enforce it. It is sampled at input accept.
// Every normalization runs on one multiplier: a start, the squared length,
// a bit-by-bit search per component and a done strobe. A triangle needs 3
// normalizations at depth 0, 6 at depth 1 and 18 at depth 2, each midpoint
// first reading its two sources from the store, then each emitted vertex
// (3, 12 or 48 vertices) is read from the store and offered on the output.
// The rate of items is bounded by the shared multiplier.
// When the receiver stalls, the current vertex holds on the output register
// and the sequencer waits. Reset returns the depth to 2, clears the vertex
// index and empties the output.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider
    import stsub_pkg::*;
#(
    parameter int FRAC_BITS  = 14,
    parameter int INDEX_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_wr_data,   // subdivision_levels
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x, center_y, center_z, corner_a_x, corner_a_y, corner_a_z,
    // corner_b_x, corner_b_y, corner_b_z (16 bits each, from the lowest bit up)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z (16 bits each), vertex_index (24 bits), lowest bit up
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int CW    = (FRAC_BITS + 3 > 17) ? FRAC_BITS + 3 : 17;
    localparam int VW    = 3 * CW;
    localparam int IDX_W = 24;

    localparam logic [3:0] T_IDLE  = 4'd0;
    localparam logic [3:0] T_NIN   = 4'd1;
    localparam logic [3:0] T_NWAIT = 4'd2;
    localparam logic [3:0] T_MRA   = 4'd3;
    localparam logic [3:0] T_MRB   = 4'd4;
    localparam logic [3:0] T_MGO   = 4'd5;
    localparam logic [3:0] T_MWAIT = 4'd6;
    localparam logic [3:0] T_ERD   = 4'd7;
    localparam logic [3:0] T_ELD   = 4'd8;
    localparam logic [3:0] T_EOUT  = 4'd9;

    logic [3:0]            r_state;
    t_level                r_cfg_level;
    t_level                r_lvl;
    logic [143:0]          r_in;
    logic [1:0]            r_vi;
    t_mid_idx              r_op;
    t_emit_idx             r_e;
    logic [VW-1:0]         r_mem [NUM_SLOTS];
    logic [VW-1:0]         r_rd;
    logic [VW-1:0]         r_opa;
    logic [INDEX_BITS-1:0] r_vcount;
    logic [VW-1:0]         r_out_pos;
    logic                  r_out_valid;
    logic                  r_out_last;

    logic                  norm_start;
    logic [VW-1:0]         norm_in;
    logic                  norm_done;
    logic [VW-1:0]         norm_out;
    logic [VW-1:0]         in_vec;
    logic [VW-1:0]         sum_vec;
    logic                  wr_en;
    t_slot                 wr_addr;
    t_slot                 rd_addr;
    t_emit_idx             emit_pos;
    logic [IDX_W-1:0]      idx_field;

    // Sign-extend the selected input vector to the internal width.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            in_vec[c*CW +: CW] = {{(CW-16){r_in[r_vi*48 + c*16 + 15]}},
                                  r_in[r_vi*48 + c*16 +: 16]};
            sum_vec[c*CW +: CW] = r_opa[c*CW +: CW] + r_rd[c*CW +: CW];
        end
    end

    assign norm_start = (r_state == T_NIN) || (r_state == T_MGO);
    assign norm_in    = (r_state == T_NIN) ? in_vec : sum_vec;

    stsub_norm #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (norm_in),
        .o_done  (norm_done),
        .o_vec   (norm_out)
    );

    // Vertex store: one write port from the normalizer, one registered read.
    assign emit_pos = emit_base(r_lvl) + r_e;
    always_comb begin
        wr_en   = norm_done && ((r_state == T_NWAIT) || (r_state == T_MWAIT));
        wr_addr = (r_state == T_NWAIT) ? t_slot'(r_vi) : MID_DST[r_op];
        case (r_state)
            T_MRA:   rd_addr = MID_SRC0[r_op];
            T_MRB:   rd_addr = MID_SRC1[r_op];
            T_ERD:   rd_addr = EMIT_TBL[emit_pos];
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= norm_out;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_cfg_level <= 2'd2;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
            r_vi        <= '0;
            r_op        <= '0;
            r_e         <= '0;
            r_lvl       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg_level <= i_cfg_wr_data;
            end
            case (r_state)
                T_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_lvl   <= (r_cfg_level > t_level'(MAX_LEVEL)) ? t_level'(MAX_LEVEL)
                                                                       : r_cfg_level;
                        r_vi    <= '0;
                        r_state <= T_NIN;
                    end
                end
                T_NIN: r_state <= T_NWAIT;
                T_NWAIT: begin
                    if (norm_done) begin
                        if (r_vi == 2'd2) begin
                            r_op <= '0;
                            r_e  <= '0;
                            r_state <= (r_lvl == 2'd0) ? T_ERD : T_MRA;
                        end else begin
                            r_vi    <= r_vi + 2'd1;
                            r_state <= T_NIN;
                        end
                    end
                end
                T_MRA: r_state <= T_MRB;
                T_MRB: r_state <= T_MGO;
                T_MGO: r_state <= T_MWAIT;
                T_MWAIT: begin
                    if (norm_done) begin
                        if (r_op == mid_count(r_lvl) - 4'd1) begin
                            r_state <= T_ERD;
                        end else begin
                            r_op    <= r_op + 4'd1;
                            r_state <= T_MRA;
                        end
                    end
                end
                T_ERD: r_state <= T_ELD;
                T_ELD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= T_EOUT;
                end
                T_EOUT: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_vcount    <= r_vcount + INDEX_BITS'(1);
                        if (r_out_last) begin
                            r_state <= T_IDLE;
                        end else begin
                            r_e     <= r_e + 6'd1;
                            r_state <= T_ERD;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == T_IDLE) && s_axis_tvalid) begin
            r_in <= s_axis_tdata;
        end
        if (r_state == T_MRB) begin
            r_opa <= r_rd;
        end
        if (r_state == T_ELD) begin
            r_out_pos  <= r_rd;
            r_out_last <= (r_e == emit_len(r_lvl) - 6'd1);
        end
    end

    assign idx_field     = IDX_W'(r_vcount);
    assign s_axis_tready = (r_state == T_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {idx_field,
                            r_out_pos[2*CW +: 16],
                            r_out_pos[CW +: 16],
                            r_out_pos[0 +: 16]};

endmodule
